// ===== rtl/agkf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agkf_pkg
// Shared types, constants and helpers of the angle/gyro Kalman filter.
// ----------------------------------------------------------------------------
package agkf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned IoW      = 32;
  localparam int unsigned FracW    = 28;
  localparam int unsigned WideW    = DataW + 8;
  localparam int unsigned PeriodW  = 29;
  localparam int unsigned NoiseW   = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QuoW     = DataW - 1;
  localparam int unsigned DenW     = DataW + 1;
  localparam int unsigned NumW     = DataW + FracW;
  localparam int unsigned CmpW     = DenW + QuoW;
  localparam int unsigned MagW     = 2 * DataW + 1 - FracW;
  localparam int unsigned CntW     = $clog2(QuoW);
  localparam int unsigned MulIdxW  = 4;
  localparam int unsigned PredLast = 4;
  localparam int unsigned CorrFirst = 5;
  localparam int unsigned MulLast  = 10;

  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(1342177);
  localparam logic [PeriodW-1:0] QaReset     = PeriodW'(268435);
  localparam logic [PeriodW-1:0] QbReset     = PeriodW'(805306);
  localparam logic [NoiseW-1:0]  RReset      = NoiseW'(134217728);
  localparam logic signed [DataW-1:0] CovReset = DataW'(1073742);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD = 3'd0,
    CFG_QA     = 3'd1,
    CFG_QB     = 3'd2,
    CFG_R      = 3'd3
  } cfg_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_PREP, OP_MUL, OP_ACC, OP_ERR,
    OP_DIV_START, OP_DIV_STEP, OP_DIV_END, OP_SNAP, OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    SA_RATE, SA_PD0, SA_PD1, SA_QB, SA_K0, SA_K1
  } srca_e;

  typedef enum logic [1:0] {
    SB_DT, SB_T0, SB_T1, SB_ERR
  } srcb_e;

  typedef enum logic [2:0] {
    DST_ANGLE, DST_BIAS, DST_P00, DST_P01, DST_P10, DST_P11
  } dst_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_MUL, ST_ACC, ST_ERR,
    ST_DSTART, ST_DSTEP, ST_DEND, ST_SNAP, ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    srca_e a;
    srcb_e b;
    dst_e  dst;
    logic  sub;
  } mstep_t;

  typedef struct packed {
    op_e    op;
    mstep_t mstep;
    logic   div_k1;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } status_t;

  function automatic mstep_t mul_step(input logic [MulIdxW-1:0] idx);
    mstep_t s;
    unique case (idx)
      4'd0:    s = '{a: SA_RATE, b: SB_DT,  dst: DST_ANGLE, sub: 1'b0};
      4'd1:    s = '{a: SA_PD0,  b: SB_DT,  dst: DST_P00,   sub: 1'b0};
      4'd2:    s = '{a: SA_PD1,  b: SB_DT,  dst: DST_P01,   sub: 1'b0};
      4'd3:    s = '{a: SA_PD1,  b: SB_DT,  dst: DST_P10,   sub: 1'b0};
      4'd4:    s = '{a: SA_QB,   b: SB_DT,  dst: DST_P11,   sub: 1'b0};
      4'd5:    s = '{a: SA_K0,   b: SB_T0,  dst: DST_P00,   sub: 1'b1};
      4'd6:    s = '{a: SA_K0,   b: SB_T1,  dst: DST_P01,   sub: 1'b1};
      4'd7:    s = '{a: SA_K1,   b: SB_T0,  dst: DST_P10,   sub: 1'b1};
      4'd8:    s = '{a: SA_K1,   b: SB_T1,  dst: DST_P11,   sub: 1'b1};
      4'd9:    s = '{a: SA_K0,   b: SB_ERR, dst: DST_ANGLE, sub: 1'b0};
      4'd10:   s = '{a: SA_K1,   b: SB_ERR, dst: DST_BIAS,  sub: 1'b0};
      default: s = '{a: SA_RATE, b: SB_DT,  dst: DST_ANGLE, sub: 1'b0};
    endcase
    return s;
  endfunction

  function automatic logic signed [DataW-1:0] sat_d(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = {{(WideW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return {1'b0, {(DataW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(DataW-1){1'b0}}};
    end
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [IoW-1:0] sat_io(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = {{(WideW-IoW+1){1'b0}}, {(IoW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return {1'b0, {(IoW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(IoW-1){1'b0}}};
    end
    return v[IoW-1:0];
  endfunction

  function automatic logic [DataW-1:0] mag_d(input logic signed [DataW-1:0] v);
    return v[DataW-1] ? DataW'(~v + 1'b1) : DataW'(v);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/agkf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agkf_ctrl
// Sequencer: steps the shared multiplier and the serial divider per sample.
// ----------------------------------------------------------------------------
module agkf_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  agkf_pkg::status_t     status_i,
  output agkf_pkg::cmd_t        cmd_o
);

  agkf_pkg::ctrl_state_e state_q, state_d;
  logic [agkf_pkg::MulIdxW-1:0] idx_q, idx_d;
  logic [agkf_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                         k1_q, k1_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= agkf_pkg::ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      k1_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      k1_q    <= k1_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    idx_d            = idx_q;
    cnt_d            = cnt_q;
    k1_d             = k1_q;
    cmd_o.op         = agkf_pkg::OP_NOP;
    cmd_o.mstep      = agkf_pkg::mul_step(idx_q);
    cmd_o.div_k1     = k1_q;
    in_stall_o       = (state_q != agkf_pkg::ST_IDLE);
    unique case (state_q)
      agkf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = agkf_pkg::OP_LOAD;
          state_d  = agkf_pkg::ST_PREP;
        end
      end
      agkf_pkg::ST_PREP: begin
        cmd_o.op = agkf_pkg::OP_PREP;
        idx_d    = '0;
        state_d  = agkf_pkg::ST_MUL;
      end
      agkf_pkg::ST_MUL: begin
        cmd_o.op = agkf_pkg::OP_MUL;
        state_d  = agkf_pkg::ST_ACC;
      end
      agkf_pkg::ST_ACC: begin
        cmd_o.op = agkf_pkg::OP_ACC;
        idx_d    = idx_q + 1'b1;
        if (idx_q == agkf_pkg::MulIdxW'(agkf_pkg::PredLast)) begin
          state_d = agkf_pkg::ST_ERR;
        end else if (idx_q == agkf_pkg::MulIdxW'(agkf_pkg::MulLast)) begin
          state_d = agkf_pkg::ST_OUT;
        end else begin
          state_d = agkf_pkg::ST_MUL;
        end
      end
      agkf_pkg::ST_ERR: begin
        cmd_o.op = agkf_pkg::OP_ERR;
        k1_d     = 1'b0;
        state_d  = agkf_pkg::ST_DSTART;
      end
      agkf_pkg::ST_DSTART: begin
        cmd_o.op = agkf_pkg::OP_DIV_START;
        cnt_d    = '0;
        state_d  = agkf_pkg::ST_DSTEP;
      end
      agkf_pkg::ST_DSTEP: begin
        cmd_o.op = agkf_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == agkf_pkg::CntW'(agkf_pkg::QuoW - 1)) begin
          state_d = agkf_pkg::ST_DEND;
        end
      end
      agkf_pkg::ST_DEND: begin
        cmd_o.op = agkf_pkg::OP_DIV_END;
        if (k1_q) begin
          state_d = agkf_pkg::ST_SNAP;
        end else begin
          k1_d    = 1'b1;
          state_d = agkf_pkg::ST_DSTART;
        end
      end
      agkf_pkg::ST_SNAP: begin
        cmd_o.op = agkf_pkg::OP_SNAP;
        idx_d    = agkf_pkg::MulIdxW'(agkf_pkg::CorrFirst);
        state_d  = agkf_pkg::ST_MUL;
      end
      agkf_pkg::ST_OUT: begin
        if (!status_i.out_blocked) begin
          cmd_o.op = agkf_pkg::OP_OUT;
          state_d  = agkf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = agkf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/agkf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agkf_datapath
// Filter state, configuration, shared multiplier, serial divider, output stage.
// ----------------------------------------------------------------------------
module agkf_datapath (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  agkf_pkg::cmd_t                       cmd_i,
  output agkf_pkg::status_t                    status_o,
  input  wire                                  cfg_we_i,
  input  wire  [agkf_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire  [agkf_pkg::CfgDataW-1:0]        cfg_data_i,
  input  wire  signed [agkf_pkg::IoW-1:0]      angle_meas_i,
  input  wire  signed [agkf_pkg::IoW-1:0]      gyro_rate_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic signed [agkf_pkg::IoW-1:0]      angle_est_o,
  output logic signed [agkf_pkg::IoW-1:0]      angle_rate_o
);

  localparam int unsigned DW = agkf_pkg::DataW;
  localparam int unsigned WW = agkf_pkg::WideW;

  logic [agkf_pkg::PeriodW-1:0] period_q, qa_q, qb_q;
  logic [agkf_pkg::NoiseW-1:0]  r_q;

  logic signed [DW-1:0] angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [DW-1:0] rate_q, pd0_q, pd1_q, err_q, k0_q, k1_q, t0_q, t1_q;
  logic signed [agkf_pkg::IoW-1:0] meas_q, gyro_q;
  logic [2*DW-1:0]      prod_q;
  logic                 pneg_q;
  logic signed [DW+1:0] e_q;
  logic [agkf_pkg::DenW-1:0] rem_q;
  logic [agkf_pkg::QuoW-1:0] sh_q, quo_q;
  logic                 dneg_q, over_q;
  logic                 out_valid_q;
  logic signed [agkf_pkg::IoW-1:0] est_q, orate_q;

  logic signed [DW-1:0] opa, opb, cur, msat, acc_new, kval, pdiv;
  logic [agkf_pkg::MagW-1:0] rnd_mag;
  logic [agkf_pkg::MagW-1:0] half;
  logic [agkf_pkg::DenW-1:0] den;
  logic [agkf_pkg::NumW-1:0] num;
  logic [agkf_pkg::DenW:0]   trial;
  logic                      e_pos;

  assign den   = e_q[agkf_pkg::DenW-1:0];
  assign e_pos = !e_q[DW+1] && (e_q != '0);
  assign pdiv  = cmd_i.div_k1 ? p10_q : p00_q;
  assign num   = {agkf_pkg::mag_d(pdiv), {agkf_pkg::FracW{1'b0}}};
  assign trial = {rem_q, sh_q[agkf_pkg::QuoW-1]};
  assign half  = agkf_pkg::MagW'(1) << (DW - 1);

  always_comb begin
    unique case (cmd_i.mstep.a)
      agkf_pkg::SA_RATE: opa = rate_q;
      agkf_pkg::SA_PD0:  opa = pd0_q;
      agkf_pkg::SA_PD1:  opa = pd1_q;
      agkf_pkg::SA_QB:   opa = DW'(qb_q);
      agkf_pkg::SA_K0:   opa = k0_q;
      agkf_pkg::SA_K1:   opa = k1_q;
      default:           opa = '0;
    endcase
    unique case (cmd_i.mstep.b)
      agkf_pkg::SB_DT:  opb = DW'(period_q);
      agkf_pkg::SB_T0:  opb = t0_q;
      agkf_pkg::SB_T1:  opb = t1_q;
      agkf_pkg::SB_ERR: opb = err_q;
      default:          opb = '0;
    endcase
    unique case (cmd_i.mstep.dst)
      agkf_pkg::DST_ANGLE: cur = angle_q;
      agkf_pkg::DST_BIAS:  cur = bias_q;
      agkf_pkg::DST_P00:   cur = p00_q;
      agkf_pkg::DST_P01:   cur = p01_q;
      agkf_pkg::DST_P10:   cur = p10_q;
      agkf_pkg::DST_P11:   cur = p11_q;
      default:             cur = '0;
    endcase
  end

  always_comb begin
    rnd_mag = agkf_pkg::MagW'(({1'b0, prod_q} + ((2*DW+1)'(1) << (agkf_pkg::FracW - 1)))
              >> agkf_pkg::FracW);
    if (rnd_mag >= half) begin
      msat = pneg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      msat = pneg_q ? DW'(-rnd_mag[DW-1:0]) : DW'(rnd_mag[DW-1:0]);
    end
    if (cmd_i.mstep.sub) begin
      acc_new = agkf_pkg::sat_d(WW'(cur) - WW'(msat));
    end else begin
      acc_new = agkf_pkg::sat_d(WW'(cur) + WW'(msat));
    end
  end

  always_comb begin
    if (!e_pos) begin
      kval = '0;
    end else if (over_q) begin
      kval = dneg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      kval = dneg_q ? DW'(-DW'(quo_q)) : DW'(quo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= agkf_pkg::PeriodReset;
      qa_q        <= agkf_pkg::QaReset;
      qb_q        <= agkf_pkg::QbReset;
      r_q         <= agkf_pkg::RReset;
      angle_q     <= '0;
      bias_q      <= '0;
      p00_q       <= agkf_pkg::CovReset;
      p01_q       <= '0;
      p10_q       <= '0;
      p11_q       <= agkf_pkg::CovReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          agkf_pkg::CFG_PERIOD: period_q <= cfg_data_i[agkf_pkg::PeriodW-1:0];
          agkf_pkg::CFG_QA:     qa_q     <= cfg_data_i[agkf_pkg::PeriodW-1:0];
          agkf_pkg::CFG_QB:     qb_q     <= cfg_data_i[agkf_pkg::PeriodW-1:0];
          agkf_pkg::CFG_R:      r_q      <= cfg_data_i[agkf_pkg::NoiseW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == agkf_pkg::OP_ACC) begin
        unique case (cmd_i.mstep.dst)
          agkf_pkg::DST_ANGLE: angle_q <= acc_new;
          agkf_pkg::DST_BIAS:  bias_q  <= acc_new;
          agkf_pkg::DST_P00:   p00_q   <= acc_new;
          agkf_pkg::DST_P01:   p01_q   <= acc_new;
          agkf_pkg::DST_P10:   p10_q   <= acc_new;
          agkf_pkg::DST_P11:   p11_q   <= acc_new;
          default: ;
        endcase
      end
      if (cmd_i.op == agkf_pkg::OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      agkf_pkg::OP_LOAD: begin
        meas_q <= angle_meas_i;
        gyro_q <= gyro_rate_i;
      end
      agkf_pkg::OP_PREP: begin
        rate_q <= agkf_pkg::sat_d(WW'(gyro_q) - WW'(bias_q));
        pd0_q  <= agkf_pkg::sat_d(WW'($signed({1'b0, qa_q})) - WW'(p01_q) - WW'(p10_q));
        pd1_q  <= agkf_pkg::sat_d(-WW'(p11_q));
      end
      agkf_pkg::OP_MUL: begin
        prod_q <= agkf_pkg::mag_d(opa) * agkf_pkg::mag_d(opb);
        pneg_q <= opa[DW-1] ^ opb[DW-1];
      end
      agkf_pkg::OP_ERR: begin
        err_q <= agkf_pkg::sat_d(WW'(meas_q) - WW'(angle_q));
        e_q   <= (DW+2)'($signed({1'b0, r_q})) + (DW+2)'(p00_q);
      end
      agkf_pkg::OP_DIV_START: begin
        over_q <= agkf_pkg::CmpW'(num) >= (agkf_pkg::CmpW'(den) << agkf_pkg::QuoW);
        rem_q  <= agkf_pkg::DenW'(num[agkf_pkg::NumW-1:agkf_pkg::QuoW]);
        sh_q   <= num[agkf_pkg::QuoW-1:0];
        quo_q  <= '0;
        dneg_q <= pdiv[DW-1];
      end
      agkf_pkg::OP_DIV_STEP: begin
        sh_q <= {sh_q[agkf_pkg::QuoW-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem_q <= agkf_pkg::DenW'(trial - {1'b0, den});
          quo_q <= {quo_q[agkf_pkg::QuoW-2:0], 1'b1};
        end else begin
          rem_q <= trial[agkf_pkg::DenW-1:0];
          quo_q <= {quo_q[agkf_pkg::QuoW-2:0], 1'b0};
        end
      end
      agkf_pkg::OP_DIV_END: begin
        if (cmd_i.div_k1) begin
          k1_q <= kval;
        end else begin
          k0_q <= kval;
        end
      end
      agkf_pkg::OP_SNAP: begin
        t0_q <= p00_q;
        t1_q <= p01_q;
      end
      agkf_pkg::OP_OUT: begin
        est_q   <= agkf_pkg::sat_io(WW'(angle_q));
        orate_q <= agkf_pkg::sat_io(WW'(gyro_q) - WW'(bias_q));
      end
      default: ;
    endcase
  end

  assign status_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign angle_est_o  = est_q;
  assign angle_rate_o = orate_q;

endmodule
`default_nettype wire

// ===== rtl/angle_gyro_kalman_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// angle_gyro_kalman_filter
// Two-state tilt Kalman filter: angle and gyro bias from accelerometer + gyro.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sample: accelerometer
//   angle and gyro rate, both signed Q4.28. One transaction per sample.
//   Output channel (out_valid_o / out_stall_i) returns the filtered angle and
//   the bias-corrected rate, signed Q4.28, one transaction per sample.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes period and noise
//   terms by index; ready is always high. Write only while the filter is idle.
//   A new sample is taken only once the previous one has finished its run,
//   which is paced by one shared 32x32 multiplier doing 11 products, each a
//   multiply then an accumulate step, and a radix-2 divider doing 31 steps per gain.
//   The output register holds a result while the receiver stalls; the next
//   sample is accepted meanwhile and waits at the end of its run until the
//   held result is taken.
//   Reset clears the estimates, loads the initial covariance and the default
//   configuration, and empties the output register.
// ----------------------------------------------------------------------------
module angle_gyro_kalman_filter (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  signed [agkf_pkg::IoW-1:0]      angle_meas_i,
  input  wire  signed [agkf_pkg::IoW-1:0]      gyro_rate_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic signed [agkf_pkg::IoW-1:0]      angle_est_o,
  output logic signed [agkf_pkg::IoW-1:0]      angle_rate_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [agkf_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire  [agkf_pkg::CfgDataW-1:0]        cfg_data_i
);

  agkf_pkg::cmd_t    cmd;
  agkf_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  agkf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  agkf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .angle_meas_i (angle_meas_i),
    .gyro_rate_i  (gyro_rate_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .angle_est_o  (angle_est_o),
    .angle_rate_o (angle_rate_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("filter not busy after sample transaction");

  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a running sample");

  a_out_needs_free_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == agkf_pkg::OP_OUT) |-> !(out_valid_o && out_stall_i))
    else $error("held result overwritten");

endmodule
`default_nettype wire

// ===== tb/tb_kalman_checker.sv =====
// ----------------------------------------------------------------------------
// tb_kalman_checker
// Watches the sample, result and configuration channels of the tilt Kalman
// filter, predicts each filtered angle and corrected rate in fixed point and
// compares every result transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_kalman_checker (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  input  wire                             in_stall_i,
  input  wire  signed [agkf_pkg::IoW-1:0] angle_meas_i,
  input  wire  signed [agkf_pkg::IoW-1:0] gyro_rate_i,
  input  wire                             out_valid_i,
  input  wire                             out_stall_i,
  input  wire  signed [agkf_pkg::IoW-1:0] angle_est_i,
  input  wire  signed [agkf_pkg::IoW-1:0] angle_rate_i,
  input  wire                             cfg_valid_i,
  input  wire                             cfg_ready_i,
  input  wire  [agkf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [agkf_pkg::CfgDataW-1:0]   cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import agkf_pkg::*;

  typedef struct packed {
    logic signed [IoW-1:0] angle;
    logic signed [IoW-1:0] rate;
  } tilt_result_t;

  tilt_result_t tilt_q[$];

  longint dt_r, qa_r, qb_r, r_r;
  longint ang_s, bias_s, p00, p01, p10, p11;

  function automatic longint clamp_w(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint clamp_d(longint v);
    return clamp_w(v, DataW);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    logic [127:0] m;
    logic [63:0] x;
    logic [63:0] y;
    bit neg;
    x = a < 0 ? -a : a;
    y = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    p = x * y;
    p = p + (128'd1 << 27);
    m = p >> 28;
    if (m > (128'd1 << 62)) m = 128'd1 << 62;
    return clamp_d(neg ? -longint'(m[63:0]) : longint'(m[63:0]));
  endfunction

  function automatic longint fx_div(longint p, longint e);
    logic [127:0] num;
    logic [127:0] q;
    num = (p < 0 ? -p : p);
    num = num << 28;
    q = num / e;
    if (q > (128'd1 << 62)) q = 128'd1 << 62;
    return clamp_d(p < 0 ? -longint'(q[63:0]) : longint'(q[63:0]));
  endfunction

  task automatic predict_tilt(longint meas, longint gyro);
    longint rate, pd0, pd1, err, e, k0, k1, t0, t1;
    tilt_result_t res;
    k0 = 0;
    k1 = 0;
    rate = clamp_d(gyro - bias_s);
    ang_s = clamp_d(ang_s + fx_mul(rate, dt_r));
    pd0 = clamp_d(qa_r - p01 - p10);
    pd1 = clamp_d(-p11);
    p00 = clamp_d(p00 + fx_mul(pd0, dt_r));
    p01 = clamp_d(p01 + fx_mul(pd1, dt_r));
    p10 = clamp_d(p10 + fx_mul(pd1, dt_r));
    p11 = clamp_d(p11 + fx_mul(qb_r, dt_r));
    err = clamp_d(meas - ang_s);
    e = r_r + p00;
    if (e > 0) begin
      k0 = fx_div(p00, e);
      k1 = fx_div(p10, e);
    end
    t0 = p00;
    t1 = p01;
    p00 = clamp_d(p00 - fx_mul(k0, t0));
    p01 = clamp_d(p01 - fx_mul(k0, t1));
    p10 = clamp_d(p10 - fx_mul(k1, t0));
    p11 = clamp_d(p11 - fx_mul(k1, t1));
    ang_s = clamp_d(ang_s + fx_mul(k0, err));
    bias_s = clamp_d(bias_s + fx_mul(k1, err));
    res.angle = IoW'(clamp_w(ang_s, IoW));
    res.rate = IoW'(clamp_w(gyro - bias_s, IoW));
    tilt_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tilt_result_t want;
    if (!rst_ni) begin
      dt_r <= longint'(PeriodReset);
      qa_r <= longint'(QaReset);
      qb_r <= longint'(QbReset);
      r_r <= longint'(RReset);
      ang_s <= 0;
      bias_s <= 0;
      p00 <= clamp_d(1073742);
      p01 <= 0;
      p10 <= 0;
      p11 <= clamp_d(1073742);
      fail_count_o <= 0;
      tilt_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PERIOD: dt_r = longint'(cfg_data_i[PeriodW-1:0]);
          CFG_QA:     qa_r = longint'(cfg_data_i[PeriodW-1:0]);
          CFG_QB:     qb_r = longint'(cfg_data_i[PeriodW-1:0]);
          CFG_R:      r_r = longint'(cfg_data_i[NoiseW-1:0]);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_tilt(angle_meas_i, gyro_rate_i);
      if (out_valid_i && !out_stall_i) begin
        if (tilt_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) $display("unexpected result transaction");
        end else begin
          want = tilt_q.pop_front();
          if (want.angle !== angle_est_i || want.rate !== angle_rate_i) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10)
              $display("mismatch: angle exp %0d act %0d, rate exp %0d act %0d",
                       want.angle, angle_est_i, want.rate, angle_rate_i);
          end
        end
      end
    end
  end

  assign pending_o = tilt_q.size();
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives samples and configuration phases into the tilt Kalman filter with
// random idling on both sides and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import agkf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IoW-1:0] angle_meas = '0;
  logic signed [IoW-1:0] gyro_rate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [IoW-1:0] angle_est;
  logic signed [IoW-1:0] angle_rate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int fail_count;
  int pending;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 1'b0;
  int quiet = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  angle_gyro_kalman_filter dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .angle_meas_i(angle_meas), .gyro_rate_i(gyro_rate),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .angle_est_o(angle_est), .angle_rate_o(angle_rate),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  tb_kalman_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .angle_meas_i(angle_meas), .gyro_rate_i(gyro_rate),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .angle_est_i(angle_est), .angle_rate_i(angle_rate),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_e idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send_sample(logic [31:0] meas, logic [31:0] gyro);
    do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    in_valid <= 1'b1;
    angle_meas <= meas;
    gyro_rate <= gyro;
    do @(posedge clk_i); while (in_stall);
    in_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
    endcase
  endfunction

  task automatic run_phase(int n);
    repeat (n) send_sample(pick_angle(), pick_angle());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_sample(32'h00000000, 32'h00000000);
    send_sample(32'h7fffffff, 32'h7fffffff);
    send_sample(32'h80000000, 32'h80000000);
    send_sample(32'hffffffff, 32'h00000001);
    send_sample(32'h55555555, 32'haaaaaaaa);
    send_sample(32'haaaaaaaa, 32'h55555555);
    drain();
    write_reg(CFG_PERIOD, 32'd0);
    write_reg(CFG_R, 32'd1);
    write_reg(CFG_QA, 32'd0);
    write_reg(CFG_QB, 32'd0);
    write_reg(cfg_e'(3'd5), 32'hffffffff);
    send_sample(32'h00010000, 32'hffff0000);
    send_sample(32'h7fffffff, 32'h80000000);
    drain();
    write_reg(CFG_PERIOD, 32'hffffffff);
    write_reg(CFG_QA, 32'd268435456);
    write_reg(CFG_QB, 32'd268435456);
    write_reg(CFG_R, 32'h7fffffff);
    send_sample(32'h80000000, 32'h7fffffff);
    send_sample(32'h00000000, 32'h00000000);
    drain();
    write_reg(CFG_PERIOD, 32'd1);
    write_reg(CFG_R, 32'd268435456);
    send_sample(32'h12345678, 32'hedcba987);
    drain();
    send_idle = 19;
    recv_idle = 52;
    write_reg(CFG_PERIOD, 32'd1342177);
    write_reg(CFG_QA, 32'd268435);
    write_reg(CFG_QB, 32'd805306);
    write_reg(CFG_R, 32'd134217728);
    run_phase(130);
    drain();
    send_idle = 52;
    recv_idle = 19;
    write_reg(CFG_PERIOD, $urandom_range(268435456, 1));
    write_reg(CFG_QA, $urandom_range(268435456));
    write_reg(CFG_QB, $urandom_range(268435456));
    write_reg(CFG_R, $urandom_range(32'h7fffffff, 1));
    run_phase(130);
    drain();
    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_PERIOD, 32'd2684355);
    write_reg(CFG_R, 32'd26843546);
    hold_off <= 1'b1;
    fork
      run_phase(6);
      begin
        repeat (600) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join
    run_phase(124);
    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/agkf_pkg.sv
rtl/agkf_ctrl.sv
rtl/agkf_datapath.sv
rtl/angle_gyro_kalman_filter.sv
tb/tb_kalman_checker.sv
tb/tb_top.sv
